// ----- rtl/mcc_pkg.sv -----
// Package with shared constants and types for the magnetometer correction block.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;
  localparam int unsigned MaxCalLengthDefault = 1000;
  localparam logic [1:0] CfgSenseAdjX = 2'd0;
  localparam logic [1:0] CfgSenseAdjY = 2'd1;
  localparam logic [1:0] CfgSenseAdjZ = 2'd2;
  localparam logic [1:0] CfgCalLength = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture input item, update held values if fresh
    logic track;    // run start handling and min/max update
    logic div_go;   // start the scale divider sequence
    logic correct;  // compute output fields
  } mcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;   // this item ends a run
    logic div_busy; // divider still working
  } mcc_sts_t;
endpackage
`default_nettype wire

// ----- rtl/mcc_datapath.sv -----
// Datapath: sensitivity scaling, min/max tracking, scale division and correction.
`timescale 1ns / 1ps
`default_nettype none
module mcc_datapath import mcc_pkg::*; #(
  parameter int unsigned MaxCalLength = MaxCalLengthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mcc_cmd_t           cmd_i,
  output mcc_sts_t                sts_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [9:0]         cfg_data_i,
  input  wire logic               data_ready_i,
  input  wire logic               overflowed_i,
  input  wire logic signed [15:0] raw_x_i,
  input  wire logic signed [15:0] raw_y_i,
  input  wire logic signed [15:0] raw_z_i,
  input  wire logic               begin_calibration_i,
  output logic signed [21:0]      field_x_o,
  output logic signed [21:0]      field_y_o,
  output logic signed [21:0]      field_z_o,
  output logic                    sample_fresh_o,
  output logic                    calibrating_o,
  output logic                    calibration_done_o
);
  localparam logic [9:0] MaxLen = 10'(MaxCalLength);

  // Configuration registers.
  logic [7:0] adj_q [3];
  logic [9:0] len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q[0] <= 8'd128; adj_q[1] <= 8'd128; adj_q[2] <= 8'd128;
      len_q <= 10'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSenseAdjX: adj_q[0] <= cfg_data_i[7:0];
        CfgSenseAdjY: adj_q[1] <= cfg_data_i[7:0];
        CfgSenseAdjZ: adj_q[2] <= cfg_data_i[7:0];
        CfgCalLength: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] raw [3];
  assign raw[0] = raw_x_i;
  assign raw[1] = raw_y_i;
  assign raw[2] = raw_z_i;

  // Held values and tracking state.
  logic signed [15:0] held_q [3];
  logic signed [15:0] min_q [3];
  logic signed [15:0] max_q [3];
  logic signed [16:0] bias_q [3];
  logic [15:0]        scale_q [3];
  logic [9:0]         rem_q;
  logic               fresh_q, done_q;
  logic               begin_q;

  logic fresh;
  assign fresh = data_ready_i & ~overflowed_i;

  logic signed [15:0] adj_v [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [24:0] p;
      logic signed [24:0] q;
      p = 25'(raw[k]) * $signed({1'b0, 9'(adj_q[k]) + 9'd128});
      q = (p + (p[24] ? 25'sd255 : 25'sd0)) >>> 8;
      if (q > 25'sd32767) adj_v[k] = 16'sh7fff;
      else if (q < -25'sd32768) adj_v[k] = 16'sh8000;
      else adj_v[k] = q[15:0];
    end
  end

  logic [9:0] start_len;
  always_comb begin
    start_len = len_q;
    if (start_len == 10'd0) start_len = 10'd1;
    if (start_len > MaxLen) start_len = MaxLen;
  end

  // The begin flag is taken with the transfer, so tracking does not rely on the port.
  logic [9:0] rem_eff;
  assign rem_eff = begin_q ? start_len : rem_q;
  assign sts_o.finish = (rem_eff == 10'd1);

  // Divider: one axis at a time, restoring, one quotient bit per cycle.
  logic [16:0] r_q [3];
  logic [18:0] s_q;
  logic [1:0]  ax_q;
  logic [5:0]  bit_q;
  logic        busy_q;
  logic [34:0] num_q;
  logic [19:0] den_q;
  logic [35:0] quo_q;
  logic [20:0] rem_div_q;
  assign sts_o.div_busy = busy_q;

  // Sum of the three axis ranges.
  function automatic logic [18:0] r_sum();
    logic [18:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + 19'(17'(max_q[k]) - 17'(min_q[k]));
    return acc;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        held_q[k] <= '0; min_q[k] <= 16'sh7fff; max_q[k] <= 16'sh8000;
        bias_q[k] <= '0; scale_q[k] <= 16'd16384; r_q[k] <= '0;
      end
      rem_q <= '0; fresh_q <= 1'b0; done_q <= 1'b0; begin_q <= 1'b0;
      busy_q <= 1'b0; ax_q <= '0; bit_q <= '0;
      s_q <= '0; num_q <= '0; den_q <= '0; quo_q <= '0; rem_div_q <= '0;
    end else begin
      if (cmd_i.load) begin
        fresh_q <= fresh;
        done_q <= 1'b0;
        begin_q <= begin_calibration_i;
        if (fresh) for (int k = 0; k < 3; k++) held_q[k] <= adj_v[k];
      end
      if (cmd_i.track) begin
        if (rem_eff != 10'd0) begin
          rem_q <= rem_eff - 10'd1;
          for (int k = 0; k < 3; k++) begin
            logic signed [15:0] mn, mx;
            mn = begin_q ? held_q[k] : min_q[k];
            mx = begin_q ? held_q[k] : max_q[k];
            if (held_q[k] < mn) mn = held_q[k];
            if (held_q[k] > mx) mx = held_q[k];
            min_q[k] <= mn;
            max_q[k] <= mx;
          end
        end else begin
          rem_q <= '0;
        end
      end
      if (cmd_i.div_go) begin
        s_q <= r_sum();
        for (int k = 0; k < 3; k++) begin
          r_q[k] <= 17'(max_q[k]) - 17'(min_q[k]);
          bias_q[k] <= 17'(max_q[k]) + 17'(min_q[k]);
        end
        busy_q <= 1'b1; ax_q <= 2'd0; bit_q <= 6'd0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        if (bit_q == 6'd0) begin
          num_q <= {s_q, 15'd0} + 35'(r_q[ax_q]) * 35'd3;
          den_q <= 20'(r_q[ax_q]) * 20'd6;
          quo_q <= '0; rem_div_q <= '0;
          bit_q <= 6'd1;
        end else if (bit_q <= 6'd35) begin
          logic [20:0] t;
          t = {rem_div_q[19:0], num_q[34]};
          num_q <= {num_q[33:0], 1'b0};
          if (t >= {1'b0, den_q}) begin
            rem_div_q <= t - {1'b0, den_q};
            quo_q <= {quo_q[34:0], 1'b1};
          end else begin
            rem_div_q <= t;
            quo_q <= {quo_q[34:0], 1'b0};
          end
          bit_q <= bit_q + 6'd1;
        end else begin
          if (r_q[ax_q] == 17'd0 || quo_q > 36'd65535) scale_q[ax_q] <= 16'hffff;
          else scale_q[ax_q] <= quo_q[15:0];
          bit_q <= 6'd0;
          if (ax_q == 2'd2) busy_q <= 1'b0;
          else ax_q <= ax_q + 2'd1;
        end
      end
    end
  end

  // Output correction, registered.
  logic signed [21:0] fld_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.correct) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [17:0] d;
        logic signed [42:0] p;
        logic [42:0] mag, rr;
        d = 18'(held_q[k]) * 18'sd2 - 18'(bias_q[k]);
        p = 43'(d) * $signed({1'b0, scale_q[k]}) * 43'sd75;
        mag = p[42] ? 43'(-p) : 43'(p);
        rr = (mag + 43'(1 << 18)) >> 19;
        if (rr > 43'd2097151 && !p[42]) fld_q[k] <= 22'sh1fffff;
        else if (rr > 43'd2097152 && p[42]) fld_q[k] <= 22'sh200000;
        else fld_q[k] <= p[42] ? 22'(-rr) : 22'(rr);
      end
    end
  end

  assign field_x_o = fld_q[0];
  assign field_y_o = fld_q[1];
  assign field_z_o = fld_q[2];
  assign sample_fresh_o = fresh_q;
  assign calibrating_o = (rem_q != 10'd0);
  assign calibration_done_o = done_q;
endmodule
`default_nettype wire

// ----- rtl/mcc_ctrl.sv -----
// Controller: sequences load, track, correct and output for each item, with a divide for the item that ends a run.
`timescale 1ns / 1ps
`default_nettype none
module mcc_ctrl import mcc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output mcc_cmd_t  cmd_o,
  input  wire mcc_sts_t sts_i
);
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StTrack = 5'b00010,
    StDiv   = 5'b00100,
    StCorr  = 5'b01000,
    StOut   = 5'b10000
  } state_e;
  state_e state_q, state_d;
  logic fin_q, fin_d;

  always_comb begin
    state_d = state_q;
    fin_d = fin_q;
    cmd_o = '0;
    in_ready = (state_q == StIdle);
    out_valid = (state_q == StOut);
    case (state_q)
      StIdle: if (in_valid) begin
        cmd_o.load = 1'b1;
        state_d = StTrack;
      end
      StTrack: begin
        cmd_o.track = 1'b1;
        fin_d = sts_i.finish;
        state_d = sts_i.finish ? StDiv : StCorr;
      end
      StDiv: begin
        if (fin_q) begin
          cmd_o.div_go = 1'b1;
          fin_d = 1'b0;
        end else if (!sts_i.div_busy) begin
          state_d = StCorr;
        end
      end
      StCorr: begin
        cmd_o.correct = 1'b1;
        state_d = StOut;
      end
      StOut: if (out_ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/magnetometer_calibrate_correct.sv -----
// Top level of the magnetometer calibration and correction block.
// Usage:
// The input channel (in_valid/in_ready) carries one sensor reading per transfer
// with ready and overflow flags and a begin-calibration flag. Each input
// transfer yields exactly one result transfer on the output channel
// (out_valid/out_ready) with corrected fields and status flags.
// The configuration channel (cfg_valid/cfg_ready) writes the sensitivity bytes
// and the run length; ready is always high. The user must write only while
// idle; the block itself does not enforce it. Order for an ordinary item: the
// input transfer, the track state, the correct state that registers the
// fields, then the output state where the result is valid until taken, then
// idle for the next input transfer. The item that ends a calibration run goes
// through the divide state after tracking: the scale divider runs one quotient
// bit per cycle, for three axes in turn, before the correct state.
// The block takes one item at a time; in_ready is low until the result is
// taken. If the receiver stalls, the result holds and no new item enters.
// Reset clears held values, bias to zero, scale to unity and ends any run.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_calibrate_correct import mcc_pkg::*; #(
  parameter int unsigned MaxCalLength = MaxCalLengthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               data_ready_i,
  input  wire logic               overflowed_i,
  input  wire logic signed [15:0] raw_x_i,
  input  wire logic signed [15:0] raw_y_i,
  input  wire logic signed [15:0] raw_z_i,
  input  wire logic               begin_calibration_i,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [21:0]      field_x_o,
  output logic signed [21:0]      field_y_o,
  output logic signed [21:0]      field_z_o,
  output logic                    sample_fresh_o,
  output logic                    calibrating_o,
  output logic                    calibration_done_o,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [9:0]         cfg_data_i
);
  mcc_cmd_t cmd;
  mcc_sts_t sts;
  assign cfg_ready = 1'b1;

  // Sequencer.
  mcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd_o(cmd), .sts_i(sts)
  );

  // Arithmetic and state.
  mcc_datapath #(.MaxCalLength(MaxCalLength)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i(cfg_valid), .cfg_index_i, .cfg_data_i,
    .data_ready_i, .overflowed_i, .raw_x_i, .raw_y_i, .raw_z_i,
    .begin_calibration_i, .field_x_o, .field_y_o, .field_z_o,
    .sample_fresh_o, .calibrating_o, .calibration_done_o
  );
endmodule
`default_nettype wire

// ----- tb/sv/magnetometer_calibrate_correct_tb.sv -----
// Self-checking testbench for the magnetometer calibration and correction block.
`timescale 1ns / 1ps
module magnetometer_calibrate_correct_tb;
  import mcc_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  // Stimulus row: one sensor reading plus, where known, the expected result.
  typedef struct {
    logic        ready;
    logic        ovf;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
    logic        start;
    logic        known;
    logic [21:0] fx;
    logic [21:0] fy;
    logic [21:0] fz;
  } reading_t;

  // One corrected result as seen on the output channel.
  typedef struct packed {
    logic [21:0] fx;
    logic [21:0] fy;
    logic [21:0] fz;
    logic        fresh;
    logic        cal;
    logic        done;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic data_ready_i = 1'b0;
  logic overflowed_i = 1'b0;
  logic signed [15:0] raw_x_i = '0;
  logic signed [15:0] raw_y_i = '0;
  logic signed [15:0] raw_z_i = '0;
  logic begin_calibration_i = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [21:0] field_x_o;
  logic signed [21:0] field_y_o;
  logic signed [21:0] field_z_o;
  logic sample_fresh_o;
  logic calibrating_o;
  logic calibration_done_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index_i = '0;
  logic [9:0] cfg_data_i = '0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // Predictor state.
  int sens_adj[3];
  int run_length;
  int held[3];
  int amin[3];
  int amax[3];
  longint bias[3];
  longint scale[3];
  int remaining;

  field_t expected_fields[$];
  logic [21:0] forced_x[$];
  logic [21:0] forced_y[$];
  logic [21:0] forced_z[$];
  bit forced_valid[$];

  always #2 clk_i = ~clk_i;

  magnetometer_calibrate_correct u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_ready_i       (data_ready_i),
    .overflowed_i       (overflowed_i),
    .raw_x_i            (raw_x_i),
    .raw_y_i            (raw_y_i),
    .raw_z_i            (raw_z_i),
    .begin_calibration_i(begin_calibration_i),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .field_x_o          (field_x_o),
    .field_y_o          (field_y_o),
    .field_z_o          (field_z_o),
    .sample_fresh_o     (sample_fresh_o),
    .calibrating_o      (calibrating_o),
    .calibration_done_o (calibration_done_o),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  function automatic void reset_predictor();
    for (int k = 0; k < 3; k++) begin
      sens_adj[k] = 128;
      held[k] = 0;
      amin[k] = 32767;
      amax[k] = -32768;
      bias[k] = 0;
      scale[k] = 16384;
    end
    run_length = 100;
    remaining = 0;
  endfunction

  // Raw count times sensitivity gain, truncated toward zero and saturated.
  function automatic int sensitivity_scale(logic signed [15:0] raw, int adj);
    int p;
    int q;
    p = int'(raw) * (adj + 128);
    q = p / 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Remove bias, apply scale and convert to 1/16 uT, rounding away from zero.
  function automatic logic [21:0] corrected_field(int h, int k);
    longint d;
    longint p;
    longint mag;
    longint r;
    d = 2 * longint'(h) - bias[k];
    p = d * scale[k] * 75;
    mag = (p < 0) ? -p : p;
    r = (mag + (64'sd1 <<< 18)) >>> 19;
    if (p < 0) r = -r;
    if (r > 2097151) r = 2097151;
    if (r < -2097152) r = -2097152;
    return r[21:0];
  endfunction

  // New bias and scale from the min/max gathered during the run.
  function automatic void close_run();
    longint r[3];
    longint s;
    longint q;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      r[k] = longint'(amax[k]) - longint'(amin[k]);
      s += r[k];
      bias[k] = longint'(amax[k]) + longint'(amin[k]);
    end
    for (int k = 0; k < 3; k++) begin
      if (r[k] == 0) begin
        q = 65535;
      end else begin
        q = (s * 32768 + 3 * r[k]) / (6 * r[k]);
        if (q > 65535) q = 65535;
      end
      scale[k] = q;
    end
  endfunction

  function automatic field_t predict_field(reading_t it);
    field_t f;
    bit fresh;
    bit done;
    int n;
    fresh = it.ready && !it.ovf;
    done = 1'b0;
    if (fresh) begin
      held[0] = sensitivity_scale(it.rx, sens_adj[0]);
      held[1] = sensitivity_scale(it.ry, sens_adj[1]);
      held[2] = sensitivity_scale(it.rz, sens_adj[2]);
    end
    if (it.start) begin
      n = run_length;
      if (n == 0) n = 1;
      if (n > MaxCalLengthDefault) n = MaxCalLengthDefault;
      remaining = n;
      for (int k = 0; k < 3; k++) begin
        amin[k] = held[k];
        amax[k] = held[k];
      end
    end
    if (remaining != 0) begin
      for (int k = 0; k < 3; k++) begin
        if (held[k] < amin[k]) amin[k] = held[k];
        if (held[k] > amax[k]) amax[k] = held[k];
      end
      remaining--;
      if (remaining == 0) begin
        close_run();
        done = 1'b1;
      end
    end
    f.fx = corrected_field(held[0], 0);
    f.fy = corrected_field(held[1], 1);
    f.fz = corrected_field(held[2], 2);
    f.fresh = fresh;
    f.cal = (remaining != 0);
    f.done = done;
    return f;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, check each transfer against the oldest expectation.
  initial begin : receiver
    int stall;
    field_t exp_f;
    logic [21:0] fx;
    logic [21:0] fy;
    logic [21:0] fz;
    bit has_forced;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      if (expected_fields.size() == 0) begin
        $error("result transfer with no expectation pending");
        error_count++;
      end else begin
        exp_f = expected_fields.pop_front();
        has_forced = forced_valid.pop_front();
        fx = forced_x.pop_front();
        fy = forced_y.pop_front();
        fz = forced_z.pop_front();
        if (has_forced && (fx != exp_f.fx || fy != exp_f.fy || fz != exp_f.fz)) begin
          $error("table value disagrees with prediction");
          error_count++;
        end
        if (field_x_o !== exp_f.fx) begin
          $error("field_x expected %0d got %0d", $signed(exp_f.fx), field_x_o);
          error_count++;
        end
        if (field_y_o !== exp_f.fy) begin
          $error("field_y expected %0d got %0d", $signed(exp_f.fy), field_y_o);
          error_count++;
        end
        if (field_z_o !== exp_f.fz) begin
          $error("field_z expected %0d got %0d", $signed(exp_f.fz), field_z_o);
          error_count++;
        end
        if (sample_fresh_o !== exp_f.fresh) begin
          $error("sample_fresh expected %0b got %0b", exp_f.fresh, sample_fresh_o);
          error_count++;
        end
        if (calibrating_o !== exp_f.cal) begin
          $error("calibrating expected %0b got %0b", exp_f.cal, calibrating_o);
          error_count++;
        end
        if (calibration_done_o !== exp_f.done) begin
          $error("calibration_done expected %0b got %0b", exp_f.done,
                 calibration_done_o);
          error_count++;
        end
      end
    end
  end

  // Sender: one input transfer, with an optional random gap before it.
  task automatic send_reading(reading_t it, bit use_gap);
    int gap;
    gap = (use_gap && $urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    expected_fields.push_back(predict_field(it));
    forced_valid.push_back(it.known);
    forced_x.push_back(it.fx);
    forced_y.push_back(it.fy);
    forced_z.push_back(it.fz);
    in_valid <= 1'b1;
    data_ready_i <= it.ready;
    overflowed_i <= it.ovf;
    raw_x_i <= it.rx;
    raw_y_i <= it.ry;
    raw_z_i <= it.rz;
    begin_calibration_i <= it.start;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Wait for every result, then idle before the next register writes.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CfgSenseAdjX: sens_adj[0] = value[7:0];
      CfgSenseAdjY: sens_adj[1] = value[7:0];
      CfgSenseAdjZ: sens_adj[2] = value[7:0];
      CfgCalLength: run_length = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic reading_t make_reading(logic rdy, logic ovf, logic [15:0] x,
                                            logic [15:0] y, logic [15:0] z,
                                            logic st);
    reading_t it;
    it.ready = rdy;
    it.ovf = ovf;
    it.rx = x;
    it.ry = y;
    it.rz = z;
    it.start = st;
    it.known = 1'b0;
    it.fx = '0;
    it.fy = '0;
    it.fz = '0;
    return it;
  endfunction

  // Random reading, full range or around a center, so calibration runs see a real spread.
  function automatic reading_t random_reading(bit wide, logic st);
    reading_t it;
    logic [15:0] v[3];
    for (int k = 0; k < 3; k++) begin
      if (wide) v[k] = 16'($urandom);
      else v[k] = 16'(int'($urandom_range(0, 4000)) - 2000 + 300 * k);
    end
    it = make_reading($urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0,
                      v[0], v[1], v[2], st);
    return it;
  endfunction

  initial begin : stimulus
    reading_t table_rows[$];
    reading_t it;
    int len;
    reset_predictor();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; known values where they follow directly from unity gain.
    it = make_reading(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    it.known = 1'b1;
    table_rows.push_back(it);
    it = make_reading(1'b1, 1'b0, 16'h7fff, 16'h8000, 16'h0000, 1'b0);
    it.known = 1'b1;
    it.fx = 22'd153595; it.fy = -22'sd153600; it.fz = '0;
    table_rows.push_back(it);
    table_rows.push_back(make_reading(1'b1, 1'b1, 16'h1234, 16'h1234, 16'h1234, 1'b0));
    table_rows.push_back(make_reading(1'b0, 1'b1, 16'hffff, 16'hffff, 16'hffff, 1'b0));
    table_rows.push_back(make_reading(1'b1, 1'b0, 16'h0001, 16'hffff, 16'h5555, 1'b0));
    table_rows.push_back(make_reading(1'b1, 1'b0, 16'haaaa, 16'h5555, 16'haaaa, 1'b0));
    foreach (table_rows[i]) send_reading(table_rows[i], 1'b1);
    drain_results();

    // Short run with zero range on every axis: scale saturates.
    write_register(CfgCalLength, 10'd3);
    send_reading(make_reading(1'b1, 1'b0, 16'd100, 16'd200, 16'd300, 1'b1), 1'b1);
    send_reading(make_reading(1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1);
    send_reading(make_reading(1'b1, 1'b1, 16'd9, 16'd9, 16'd9, 1'b0), 1'b1);
    drain_results();

    // Length 0 counts as one, and a run restarted before its end.
    write_register(CfgCalLength, 10'd0);
    send_reading(make_reading(1'b1, 1'b0, 16'h8000, 16'h7fff, 16'h0010, 1'b1), 1'b1);
    drain_results();
    write_register(CfgCalLength, 10'd4);
    send_reading(make_reading(1'b1, 1'b0, 16'd500, 16'hfe00, 16'd50, 1'b1), 1'b1);
    send_reading(make_reading(1'b1, 1'b0, 16'hfc00, 16'd900, 16'd70, 1'b0), 1'b1);
    send_reading(make_reading(1'b1, 1'b0, 16'd1500, 16'hf000, 16'd40, 1'b1), 1'b1);
    for (int i = 0; i < 4; i++) send_reading(random_reading(1'b0, 1'b0), 1'b1);
    drain_results();

    // Extreme sensitivity bytes with full-scale readings; length above maximum.
    write_register(CfgSenseAdjX, 10'h0ff);
    write_register(CfgSenseAdjY, 10'h000);
    write_register(CfgSenseAdjZ, 10'h3ff);
    write_register(CfgCalLength, 10'h3ff);
    send_reading(make_reading(1'b1, 1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b0), 1'b1);
    send_reading(make_reading(1'b1, 1'b0, 16'h8000, 16'h8000, 16'h7fff, 1'b0), 1'b1);
    drain_results();

    // Random phases; sensitivity and run length change between phases.
    for (int phase = 0; phase < 12; phase++) begin
      write_register(CfgSenseAdjX, 10'($urandom_range(0, 255)));
      write_register(CfgSenseAdjY, 10'($urandom_range(0, 255)));
      write_register(CfgSenseAdjZ, 10'($urandom_range(0, 255)));
      case (phase % 4)
        0: len = $urandom_range(1, 8);
        1: len = $urandom_range(9, 60);
        2: len = $urandom_range(0, 3);
        default: len = (phase == 11) ? 1000 : $urandom_range(60, 150);
      endcase
      write_register(CfgCalLength, 10'(len));
      for (int i = 0; i < 110; i++) begin
        if (i == 0 || $urandom_range(0, 40) == 0)
          it = random_reading($urandom_range(0, 9) == 0, 1'b1);
        else
          it = random_reading($urandom_range(0, 9) == 0, 1'b0);
        send_reading(it, (phase % 3) != 1);
      end
      drain_results();
    end

    drain_results();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
